/* rtl/core/diff_drive_tracking_feedback_assert.svh */
// Assertion macros used by the checker of this block.
`ifndef DIFF_DRIVE_TRACKING_FEEDBACK_ASSERT_SVH
`define DIFF_DRIVE_TRACKING_FEEDBACK_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define DDTF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after reset was applied.
`define DDTF_ASSERT_RESET(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ddtf_pkg.sv */
package ddtf_pkg;

    localparam int ANG_WIDTH    = 19;
    localparam int ANG_FRAC     = 30;
    localparam int ETH_W        = ANG_WIDTH + 2;
    localparam int CORDIC_ITERS = 24;
    localparam int CORDIC_W     = 34;
    localparam int NUM_GAINS    = 6;
    localparam int REG_IDX_W    = 3;

    localparam logic signed [CORDIC_W-1:0] CORDIC_K = 34'sd652032874;
    localparam longint PI_A      = 64'sd3373259426;
    localparam longint HALF_PI_A = 64'sd1686629713;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN_V_EX  = 3'd0,
        REG_GAIN_V_EY  = 3'd1,
        REG_GAIN_V_ETH = 3'd2,
        REG_GAIN_W_EX  = 3'd3,
        REG_GAIN_W_EY  = 3'd4,
        REG_GAIN_W_ETH = 3'd5,
        REG_HALF_TRACK = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Arctangent of 2^-i in Q.30.
    function automatic logic [ANG_FRAC-1:0] atan_val(input logic [4:0] idx);
        logic [ANG_FRAC-1:0] v;
        case (idx)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/diff_drive_tracking_feedback.sv */
// Trajectory-tracking feedback for a differential-drive cart. Each transaction on the
// input channel carries measured and reference pose plus feed-forward speed and turn
// rate; one result transaction follows with the commanded speed, turn rate and the
// left/right wheel speeds, all fixed point with FRAC_BITS fraction bits and saturated.
// The block takes one transaction per clock cycle when nothing stalls it. Each one
// passes through the 24-stage CORDIC for the heading's sine and cosine, then the
// rotation multipliers, the gain multipliers and the wheel-speed
// multiplier. A four-entry queue sits between the rotation front end and the gain
// back end, so an output stall reaches the input only after that queue fills. Gain and
// half-track registers are written through the configuration channel, which is always
// ready; write them only while no transaction is in flight.
module diff_drive_tracking_feedback #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [DATA_WIDTH-1:0]          i_pos_x,
    input  logic signed [DATA_WIDTH-1:0]          i_pos_y,
    input  logic signed [ddtf_pkg::ANG_WIDTH-1:0] i_heading,
    input  logic signed [DATA_WIDTH-1:0]          i_ref_x,
    input  logic signed [DATA_WIDTH-1:0]          i_ref_y,
    input  logic signed [ddtf_pkg::ANG_WIDTH-1:0] i_ref_heading,
    input  logic signed [DATA_WIDTH-1:0]          i_ff_speed,
    input  logic signed [DATA_WIDTH-1:0]          i_ff_turn,

    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [DATA_WIDTH-1:0]          o_cmd_speed,
    output logic signed [DATA_WIDTH-1:0]          o_cmd_turn,
    output logic signed [DATA_WIDTH-1:0]          o_wheel_left,
    output logic signed [DATA_WIDTH-1:0]          o_wheel_right,

    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ddtf_pkg::REG_IDX_W-1:0]        i_cfg_index,
    input  logic [DATA_WIDTH-1:0]                 i_cfg_data
);

    localparam int QW = 4 * DATA_WIDTH + ddtf_pkg::ETH_W;

    logic signed [DATA_WIDTH-1:0] r_gain [ddtf_pkg::NUM_GAINS];
    logic [DATA_WIDTH-2:0]        r_half_track;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ddtf_pkg::NUM_GAINS; k++) begin
                r_gain[k] <= '0;
            end
            r_half_track <= (DATA_WIDTH-1)'(16384);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (ddtf_pkg::t_reg_idx'(i_cfg_index))
                ddtf_pkg::REG_GAIN_V_EX:  r_gain[int'(ddtf_pkg::REG_GAIN_V_EX)]  <= i_cfg_data;
                ddtf_pkg::REG_GAIN_V_EY:  r_gain[int'(ddtf_pkg::REG_GAIN_V_EY)]  <= i_cfg_data;
                ddtf_pkg::REG_GAIN_V_ETH: r_gain[int'(ddtf_pkg::REG_GAIN_V_ETH)] <= i_cfg_data;
                ddtf_pkg::REG_GAIN_W_EX:  r_gain[int'(ddtf_pkg::REG_GAIN_W_EX)]  <= i_cfg_data;
                ddtf_pkg::REG_GAIN_W_EY:  r_gain[int'(ddtf_pkg::REG_GAIN_W_EY)]  <= i_cfg_data;
                ddtf_pkg::REG_GAIN_W_ETH: r_gain[int'(ddtf_pkg::REG_GAIN_W_ETH)] <= i_cfg_data;
                ddtf_pkg::REG_HALF_TRACK: r_half_track <= i_cfg_data[DATA_WIDTH-2:0];
                default: ;
            endcase
        end
    end

    ddtf_pkg::t_q_status q_status;
    logic                q_push;
    logic                q_pop;
    logic [QW-1:0]       q_push_data;
    logic [QW-1:0]       q_data;

    ddtf_front #(
        .DW (DATA_WIDTH),
        .FB (FRAC_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_heading     (i_heading),
        .i_ref_x       (i_ref_x),
        .i_ref_y       (i_ref_y),
        .i_ref_heading (i_ref_heading),
        .i_ff_speed    (i_ff_speed),
        .i_ff_turn     (i_ff_turn),
        .i_q_status    (q_status),
        .i_q_pop       (q_pop),
        .o_push        (q_push),
        .o_push_data   (q_push_data)
    );

    ddtf_queue #(
        .W (QW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_data      (q_data),
        .o_status    (q_status)
    );

    ddtf_back #(
        .DW (DATA_WIDTH),
        .FB (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_gain        (r_gain),
        .i_half_track  (r_half_track),
        .i_q_status    (q_status),
        .i_q_data      (q_data),
        .o_pop         (q_pop),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_cmd_speed   (o_cmd_speed),
        .o_cmd_turn    (o_cmd_turn),
        .o_wheel_left  (o_wheel_left),
        .o_wheel_right (o_wheel_right)
    );

endmodule

/* rtl/core/ddtf_cordic.sv */
module ddtf_cordic #(
    parameter int ZW  = 34,
    parameter int SBW = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic signed [ZW-1:0]                   i_z,
    input  logic [SBW-1:0]                         i_sb,
    output logic                                   o_valid,
    output logic signed [ddtf_pkg::CORDIC_W-1:0]   o_x,
    output logic signed [ddtf_pkg::CORDIC_W-1:0]   o_y,
    output logic [SBW-1:0]                         o_sb
);

    localparam int N  = ddtf_pkg::CORDIC_ITERS;
    localparam int CW = ddtf_pkg::CORDIC_W;

    logic signed [CW-1:0] r_x  [N];
    logic signed [CW-1:0] r_y  [N];
    logic signed [ZW-1:0] r_z  [N-1];
    logic [SBW-1:0]       r_sb [N];
    logic                 r_v  [N];

    genvar g;
    for (g = 0; g < N; g++) begin : g_stage
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        logic [SBW-1:0]       sb_in;
        logic                 v_in;
        logic signed [ZW-1:0] ang;

        if (g == 0) begin : g_first
            assign x_in  = ddtf_pkg::CORDIC_K;
            assign y_in  = '0;
            assign z_in  = i_z;
            assign sb_in = i_sb;
            assign v_in  = i_valid;
        end else begin : g_rest
            assign x_in  = r_x[g-1];
            assign y_in  = r_y[g-1];
            assign z_in  = r_z[g-1];
            assign sb_in = r_sb[g-1];
            assign v_in  = r_v[g-1];
        end

        assign ang = ZW'({1'b0, ddtf_pkg::atan_val(5'(g))});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!z_in[ZW-1]) begin
                    r_x[g] <= x_in - (y_in >>> g);
                    r_y[g] <= y_in + (x_in >>> g);
                end else begin
                    r_x[g] <= x_in + (y_in >>> g);
                    r_y[g] <= y_in - (x_in >>> g);
                end
                r_sb[g] <= sb_in;
            end
        end

        // The angle left after the last rotation is not needed.
        if (g < N - 1) begin : g_z
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_z[g] <= z_in[ZW-1] ? z_in + ang : z_in - ang;
                end
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_x     = r_x[N-1];
    assign o_y     = r_y[N-1];
    assign o_sb    = r_sb[N-1];

endmodule

/* rtl/core/ddtf_front.sv */
module ddtf_front #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [DW-1:0]                  i_pos_x,
    input  logic signed [DW-1:0]                  i_pos_y,
    input  logic signed [ddtf_pkg::ANG_WIDTH-1:0] i_heading,
    input  logic signed [DW-1:0]                  i_ref_x,
    input  logic signed [DW-1:0]                  i_ref_y,
    input  logic signed [ddtf_pkg::ANG_WIDTH-1:0] i_ref_heading,
    input  logic signed [DW-1:0]                  i_ff_speed,
    input  logic signed [DW-1:0]                  i_ff_turn,
    input  ddtf_pkg::t_q_status                   i_q_status,
    input  logic                                  i_q_pop,
    output logic                                  o_push,
    output logic [4*DW+ddtf_pkg::ETH_W-1:0]       o_push_data
);

    localparam int ETW = ddtf_pkg::ETH_W;
    localparam int CW  = ddtf_pkg::CORDIC_W;
    localparam int AWA = ddtf_pkg::ANG_WIDTH;
    localparam int ZSH = ddtf_pkg::ANG_FRAC - FB;
    localparam int ZW  = ((AWA + ZSH) > 33 ? (AWA + ZSH) : 33) + 2;
    localparam int PW  = CW + DW + 1;
    localparam int AW  = PW + 1;
    localparam int S   = ddtf_pkg::ANG_FRAC;
    localparam longint PI_F = (ddtf_pkg::PI_A + (64'sd1 <<< (ZSH - 1))) >>> ZSH;
    localparam logic signed [AW-1:0] RND     = AW'(64'sd1) <<< (S - 1);
    localparam logic signed [AW-1:0] SAT_MAX = AW'((64'sd1 <<< (DW - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] SAT_MIN = ~SAT_MAX;

    typedef struct packed {
        logic                  flip;
        logic signed [ETW-1:0] eth;
        logic signed [DW-1:0]  ffv;
        logic signed [DW-1:0]  ffw;
        logic signed [DW:0]    dx;
        logic signed [DW:0]    dy;
    } t_side;

    function automatic logic signed [DW-1:0] rnd_sat(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0] t;
        t = (acc + RND) >>> S;
        if (t > SAT_MAX) begin
            return SAT_MAX[DW-1:0];
        end else if (t < SAT_MIN) begin
            return SAT_MIN[DW-1:0];
        end
        return t[DW-1:0];
    endfunction

    logic en;

    // Input capture: position deltas, wrapped heading error, folded angle.
    logic signed [AWA:0]  dth;
    logic signed [ETW-1:0] eth_c;
    logic signed [ZW-1:0] th_z;
    logic signed [ZW-1:0] z_c;
    logic                 flip_c;
    t_side                side_c;

    always_comb begin
        dth = (AWA+1)'(i_ref_heading) - (AWA+1)'(i_heading);
        if (longint'(dth) > PI_F) begin
            eth_c = ETW'(dth) - ETW'(2 * PI_F);
        end else if (longint'(dth) < -PI_F) begin
            eth_c = ETW'(dth) + ETW'(2 * PI_F);
        end else begin
            eth_c = ETW'(dth);
        end

        th_z = ZW'(i_heading) <<< ZSH;
        if (longint'(th_z) > ddtf_pkg::HALF_PI_A) begin
            z_c    = th_z - ZW'(ddtf_pkg::PI_A);
            flip_c = 1'b1;
        end else if (longint'(th_z) < -ddtf_pkg::HALF_PI_A) begin
            z_c    = th_z + ZW'(ddtf_pkg::PI_A);
            flip_c = 1'b1;
        end else begin
            z_c    = th_z;
            flip_c = 1'b0;
        end

        side_c.flip = flip_c;
        side_c.eth  = eth_c;
        side_c.ffv  = i_ff_speed;
        side_c.ffw  = i_ff_turn;
        side_c.dx   = (DW+1)'(i_ref_x) - (DW+1)'(i_pos_x);
        side_c.dy   = (DW+1)'(i_ref_y) - (DW+1)'(i_pos_y);
    end

    logic                 r0_v;
    logic signed [ZW-1:0] r0_z;
    t_side                r0_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_z    <= z_c;
            r0_side <= side_c;
        end
    end

    logic                 cor_v;
    logic signed [CW-1:0] cor_x;
    logic signed [CW-1:0] cor_y;
    t_side                cor_side;

    ddtf_cordic #(
        .ZW  (ZW),
        .SBW ($bits(t_side))
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r0_v),
        .i_z     (r0_z),
        .i_sb    (r0_side),
        .o_valid (cor_v),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .o_sb    (cor_side)
    );

    // Rotation into the cart frame: four products, then two rounded sums.
    logic signed [CW-1:0] cos_c;
    logic signed [CW-1:0] sin_c;

    assign cos_c = cor_side.flip ? -cor_x : cor_x;
    assign sin_c = cor_side.flip ? -cor_y : cor_y;

    logic                  r1_v;
    logic signed [PW-1:0]  r1_cdx;
    logic signed [PW-1:0]  r1_sdy;
    logic signed [PW-1:0]  r1_sdx;
    logic signed [PW-1:0]  r1_cdy;
    logic signed [ETW-1:0] r1_eth;
    logic signed [DW-1:0]  r1_ffv;
    logic signed [DW-1:0]  r1_ffw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= cor_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cdx <= cos_c * cor_side.dx;
            r1_sdy <= sin_c * cor_side.dy;
            r1_sdx <= sin_c * cor_side.dx;
            r1_cdy <= cos_c * cor_side.dy;
            r1_eth <= cor_side.eth;
            r1_ffv <= cor_side.ffv;
            r1_ffw <= cor_side.ffw;
        end
    end

    logic                  r2_v;
    logic signed [DW-1:0]  r2_ex;
    logic signed [DW-1:0]  r2_ey;
    logic signed [ETW-1:0] r2_eth;
    logic signed [DW-1:0]  r2_ffv;
    logic signed [DW-1:0]  r2_ffw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ex  <= rnd_sat(AW'(r1_cdx) + AW'(r1_sdy));
            r2_ey  <= rnd_sat(AW'(r1_cdy) - AW'(r1_sdx));
            r2_eth <= r1_eth;
            r2_ffv <= r1_ffv;
            r2_ffw <= r1_ffw;
        end
    end

    // The whole front moves together; it holds only when its last stage cannot drain.
    assign en          = !r2_v || !i_q_status.full || i_q_pop;
    assign o_stall     = !en;
    assign o_push      = r2_v && en;
    assign o_push_data = {r2_ex, r2_ey, r2_eth, r2_ffv, r2_ffw};

endmodule

/* rtl/core/ddtf_queue.sv */
module ddtf_queue #(
    parameter int W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [W-1:0]         i_push_data,
    input  logic                 i_pop,
    output logic [W-1:0]         o_data,
    output ddtf_pkg::t_q_status  o_status
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

/* rtl/core/ddtf_back.sv */
module ddtf_back #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [DW-1:0]              i_gain [ddtf_pkg::NUM_GAINS],
    input  logic [DW-2:0]                     i_half_track,
    input  ddtf_pkg::t_q_status               i_q_status,
    input  logic [4*DW+ddtf_pkg::ETH_W-1:0]   i_q_data,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [DW-1:0]              o_cmd_speed,
    output logic signed [DW-1:0]              o_cmd_turn,
    output logic signed [DW-1:0]              o_wheel_left,
    output logic signed [DW-1:0]              o_wheel_right
);

    localparam int ETW = ddtf_pkg::ETH_W;
    localparam int AW  = 2 * DW + 3;
    localparam logic signed [AW-1:0] RND     = AW'(64'sd1) <<< (FB - 1);
    localparam logic signed [AW-1:0] SAT_MAX = AW'((64'sd1 <<< (DW - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] SAT_MIN = ~SAT_MAX;

    typedef struct packed {
        logic signed [DW-1:0]  ex;
        logic signed [DW-1:0]  ey;
        logic signed [ETW-1:0] eth;
        logic signed [DW-1:0]  ffv;
        logic signed [DW-1:0]  ffw;
    } t_err;

    function automatic logic signed [DW-1:0] rnd_sat(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0] t;
        t = (acc + RND) >>> FB;
        if (t > SAT_MAX) begin
            return SAT_MAX[DW-1:0];
        end else if (t < SAT_MIN) begin
            return SAT_MIN[DW-1:0];
        end
        return t[DW-1:0];
    endfunction

    logic en;
    t_err q_item;

    assign en     = !(o_valid && i_stall);
    assign o_pop  = !i_q_status.empty && en;
    assign q_item = i_q_data;

    // Gain products.
    logic                 r1_v;
    logic signed [AW-1:0] r1_vx, r1_vy, r1_vt;
    logic signed [AW-1:0] r1_wx, r1_wy, r1_wt;
    logic signed [DW-1:0] r1_ffv;
    logic signed [DW-1:0] r1_ffw;

    // Summed commands.
    logic                 r2_v;
    logic signed [DW-1:0] r2_speed;
    logic signed [DW-1:0] r2_turn;

    // Half-track times turn rate.
    logic                 r3_v;
    logic signed [AW-1:0] r3_at;
    logic signed [DW-1:0] r3_speed;
    logic signed [DW-1:0] r3_turn;
    logic signed [DW-1:0] half_track_s;

    assign half_track_s = {1'b0, i_half_track};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r1_v    <= o_pop;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            o_valid <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_vx  <= i_gain[int'(ddtf_pkg::REG_GAIN_V_EX)]  * q_item.ex;
            r1_vy  <= i_gain[int'(ddtf_pkg::REG_GAIN_V_EY)]  * q_item.ey;
            r1_vt  <= i_gain[int'(ddtf_pkg::REG_GAIN_V_ETH)] * q_item.eth;
            r1_wx  <= i_gain[int'(ddtf_pkg::REG_GAIN_W_EX)]  * q_item.ex;
            r1_wy  <= i_gain[int'(ddtf_pkg::REG_GAIN_W_EY)]  * q_item.ey;
            r1_wt  <= i_gain[int'(ddtf_pkg::REG_GAIN_W_ETH)] * q_item.eth;
            r1_ffv <= q_item.ffv;
            r1_ffw <= q_item.ffw;

            r2_speed <= rnd_sat(r1_vx + r1_vy + r1_vt + (AW'(r1_ffv) <<< FB));
            r2_turn  <= rnd_sat(r1_wx + r1_wy + r1_wt + (AW'(r1_ffw) <<< FB));

            r3_at    <= half_track_s * r2_turn;
            r3_speed <= r2_speed;
            r3_turn  <= r2_turn;

            o_cmd_speed   <= r3_speed;
            o_cmd_turn    <= r3_turn;
            o_wheel_left  <= rnd_sat((AW'(r3_speed) <<< FB) - r3_at);
            o_wheel_right <= rnd_sat((AW'(r3_speed) <<< FB) + r3_at);
        end
    end

endmodule

/* rtl/core/ddtf_chk.sv */
`include "diff_drive_tracking_feedback_assert.svh"

module ddtf_chk #(
    parameter int DW = 32
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input logic [DW-1:0] o_cmd_speed,
    input logic [DW-1:0] o_cmd_turn,
    input logic [DW-1:0] o_wheel_left,
    input logic [DW-1:0] o_wheel_right
);

    // A result held back by the receiver stays offered.
    `DDTF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")

    `DDTF_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_cmd_speed) && $stable(o_cmd_turn) && $stable(o_wheel_left) && $stable(o_wheel_right), "stalled result changed")

    `DDTF_ASSERT_RESET(a_rst_out, i_clk, i_rst_n, !o_out_valid, "result offered after reset")

    // An empty pipeline must be able to take a transaction.
    `DDTF_ASSERT_RESET(a_rst_in, i_clk, i_rst_n, !o_in_stall, "input stalled after reset")

endmodule

bind diff_drive_tracking_feedback ddtf_chk #(
    .DW (DATA_WIDTH)
) u_ddtf_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_cmd_speed   (o_cmd_speed),
    .o_cmd_turn    (o_cmd_turn),
    .o_wheel_left  (o_wheel_left),
    .o_wheel_right (o_wheel_right)
);
